>>> sv/s2dcc_pkg.sv
package s2dcc_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int PROD_W       = 2 * SAMPLE_BITS;
  localparam int DOT_W        = 40;
  localparam int POS_W        = 6;
  localparam int WIDX_W       = 5;
  localparam int SIDE_REG_W   = 7;
  localparam int KSIDE_REG_W  = 3;
  localparam int STRIDE_REG_W = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;
  localparam int PH_W         = 3;

  localparam logic [SIDE_REG_W-1:0]   IMAGE_SIDE_RST  = 7'd8;
  localparam logic [KSIDE_REG_W-1:0]  KERNEL_SIDE_RST = 3'd3;
  localparam logic [STRIDE_REG_W-1:0] STRIDE_RST      = 3'd1;

  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIDE  = 2'd0,
    REG_KERNEL_SIDE = 2'd1,
    REG_STRIDE      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                     command;
    logic [WIDX_W-1:0]        weight_index;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot_product;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    frame_last;
  } out_item_t;

endpackage

>>> sv/s2dcc_cell.sv
module s2dcc_cell (
  input  logic                                     clk_i,
  input  logic                                     shift_i,
  input  logic                                     adv_i,
  input  logic                                     active_i,
  input  logic signed [s2dcc_pkg::SAMPLE_BITS-1:0] din_i,
  input  logic signed [s2dcc_pkg::SAMPLE_BITS-1:0] weight_i,
  output logic signed [s2dcc_pkg::SAMPLE_BITS-1:0] dout_o,
  output logic signed [s2dcc_pkg::PROD_W-1:0]      prod_o
);
  import s2dcc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] win_q;
  logic signed [PROD_W-1:0]      prod_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= din_i;
    end
  end

  // unused cells contribute zero
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= active_i ? PROD_W'(win_q) * PROD_W'(weight_i) : '0;
    end
  end

  assign dout_o = win_q;
  assign prod_o = prod_q;

endmodule

>>> sv/s2dcc_adder_tree.sv
module s2dcc_adder_tree #(
  parameter int  N_IN  = 25,
  localparam int NP    = (N_IN < 2) ? 2 : (1 << $clog2(N_IN)),
  localparam int LVLS  = $clog2(NP),
  localparam int ACC_W = s2dcc_pkg::PROD_W + LVLS
) (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic signed [s2dcc_pkg::PROD_W-1:0] terms_i [N_IN],
  output logic signed [ACC_W-1:0]             sum_o
);
  import s2dcc_pkg::*;

  logic signed [ACC_W-1:0] leaf   [NP];
  logic signed [ACC_W-1:0] node_q [1:NP-1];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < N_IN) begin : g_term
      assign leaf[i] = ACC_W'(terms_i[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // heap order: node n sums 2n and 2n+1, every node registered
  for (genvar n = 1; n < NP; n++) begin : g_node
    logic signed [ACC_W-1:0] lhs;
    logic signed [ACC_W-1:0] rhs;
    if (2 * n >= NP) begin : g_bottom
      assign lhs = leaf[2*n-NP];
      assign rhs = leaf[2*n+1-NP];
    end else begin : g_inner
      assign lhs = node_q[2*n];
      assign rhs = node_q[2*n+1];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        node_q[n] <= lhs + rhs;
      end
    end
  end

  assign sum_o = node_q[1];

endmodule

>>> sv/s2dcc_line_store.sv
module s2dcc_line_store #(
  parameter int  DEPTH = 64,
  parameter int  WIDTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import s2dcc_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (wr_en_i) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // read and write of the same column in one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (adv_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> sv/strided_2d_cross_correlation_unit.sv
// channel   direction  handshake                  payload
// cfg       in         cfg_we_i                   cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o    in_item_i  (in_item_t)
// out       out        out_valid_o / out_stall_i  out_item_o (out_item_t)
//
// One item per cycle while the output is not stalled. A result passes through line store read,
// window shift, cell multiply, registered adder tree, saturation into the output register.
// Reset clears registers, weights and position; line store and window are not cleared.
// A stall while an output is valid freezes the whole pipe and stalls the input.
module strided_2d_cross_correlation_unit #(
  parameter int MAX_IMAGE_SIDE  = 64,
  parameter int MAX_KERNEL_SIDE = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [s2dcc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [s2dcc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  s2dcc_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output s2dcc_pkg::out_item_t                out_item_o
);
  import s2dcc_pkg::*;

  localparam int MAXK      = MAX_KERNEL_SIDE;
  localparam int KSQ       = MAXK * MAXK;
  localparam int IDX_W     = $clog2(MAX_IMAGE_SIDE);
  localparam int CW        = IDX_W + 1;
  localparam int KW        = $clog2(MAXK + 1);
  localparam int LS_ROWS   = (MAXK > 1) ? MAXK - 1 : 1;
  localparam int LS_W      = LS_ROWS * SAMPLE_BITS;
  localparam int NP        = (KSQ < 2) ? 2 : (1 << $clog2(KSQ));
  localparam int TREE_LVLS = $clog2(NP);
  localparam int ACC_W     = PROD_W + TREE_LVLS;
  localparam int MDEPTH    = TREE_LVLS + 2;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [POS_W-1:0] orow;
    logic [POS_W-1:0] ocol;
  } meta_t;

  // configuration
  logic [SIDE_REG_W-1:0]   image_side_q;
  logic [KSIDE_REG_W-1:0]  kernel_side_q;
  logic [STRIDE_REG_W-1:0] stride_q;
  logic                    cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_IMAGE_SIDE ||
                                cfg_index_i == REG_KERNEL_SIDE ||
                                cfg_index_i == REG_STRIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_side_q  <= IMAGE_SIDE_RST;
      kernel_side_q <= KERNEL_SIDE_RST;
      stride_q      <= STRIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_SIDE:  image_side_q  <= cfg_data_i[SIDE_REG_W-1:0];
        REG_KERNEL_SIDE: kernel_side_q <= cfg_data_i[KSIDE_REG_W-1:0];
        REG_STRIDE:      stride_q      <= cfg_data_i[STRIDE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]           n_eff;
  logic [KW-1:0]           k_eff;
  logic [STRIDE_REG_W-1:0] s_eff;

  always_comb begin
    if (image_side_q == '0) begin
      n_eff = CW'(1);
    end else if (int'(image_side_q) > MAX_IMAGE_SIDE) begin
      n_eff = CW'(MAX_IMAGE_SIDE);
    end else begin
      n_eff = CW'(image_side_q);
    end
  end

  always_comb begin
    int kv;
    kv = (kernel_side_q == '0) ? 1 : int'(kernel_side_q);
    if (kv > MAXK) kv = MAXK;
    if (kv > int'(n_eff)) kv = int'(n_eff);
    k_eff = KW'(kv);
  end

  assign s_eff = (stride_q == '0) ? STRIDE_REG_W'(1) : stride_q;

  // handshake
  logic adv;
  logic accept;
  logic pixel_acc;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign pixel_acc  = accept && (in_item_i.command == CMD_PIXEL);

  // raster position and stride phase of the window origin
  logic [IDX_W-1:0] pixel_col_q, pixel_row_q, c_out_q, r_out_q;
  logic [PH_W-1:0]  c_ph_q, r_ph_q;
  logic             col_on, row_on, wrap_col, wrap_row, c_ph_wrap, r_ph_wrap;
  logic             emit, last_pos;

  assign col_on    = int'(pixel_col_q) + 1 >= int'(k_eff);
  assign row_on    = int'(pixel_row_q) + 1 >= int'(k_eff);
  assign wrap_col  = int'(pixel_col_q) + 1 >= int'(n_eff);
  assign wrap_row  = int'(pixel_row_q) + 1 >= int'(n_eff);
  assign c_ph_wrap = ({1'b0, c_ph_q} + 4'd1) == {1'b0, s_eff};
  assign r_ph_wrap = ({1'b0, r_ph_q} + 4'd1) == {1'b0, s_eff};
  assign emit      = col_on && row_on && (c_ph_q == '0) && (r_ph_q == '0);
  assign last_pos  = (int'(pixel_col_q) + int'(s_eff) >= int'(n_eff)) &&
                     (int'(pixel_row_q) + int'(s_eff) >= int'(n_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_col_q <= '0;
      pixel_row_q <= '0;
      c_ph_q      <= '0;
      r_ph_q      <= '0;
      c_out_q     <= '0;
      r_out_q     <= '0;
    end else if (cfg_hit) begin
      pixel_col_q <= '0;
      pixel_row_q <= '0;
      c_ph_q      <= '0;
      r_ph_q      <= '0;
      c_out_q     <= '0;
      r_out_q     <= '0;
    end else if (pixel_acc) begin
      if (wrap_col) begin
        pixel_col_q <= '0;
        c_ph_q      <= '0;
        c_out_q     <= '0;
        if (wrap_row) begin
          pixel_row_q <= '0;
          r_ph_q      <= '0;
          r_out_q     <= '0;
        end else begin
          pixel_row_q <= pixel_row_q + IDX_W'(1);
          if (int'(pixel_row_q) + 1 == int'(k_eff) - 1) begin
            r_ph_q  <= '0;
            r_out_q <= '0;
          end else if (row_on) begin
            if (r_ph_wrap) begin
              r_ph_q  <= '0;
              r_out_q <= r_out_q + IDX_W'(1);
            end else begin
              r_ph_q <= r_ph_q + PH_W'(1);
            end
          end
        end
      end else begin
        pixel_col_q <= pixel_col_q + IDX_W'(1);
        if (int'(pixel_col_q) + 1 == int'(k_eff) - 1) begin
          c_ph_q  <= '0;
          c_out_q <= '0;
        end else if (col_on) begin
          if (c_ph_wrap) begin
            c_ph_q  <= '0;
            c_out_q <= c_out_q + IDX_W'(1);
          end else begin
            c_ph_q <= c_ph_q + PH_W'(1);
          end
        end
      end
    end
  end

  // input stage, line store read in flight
  logic             s0_valid_q;
  in_item_t         s0_item_q;
  logic [IDX_W-1:0] s0_col_q;
  meta_t            s0_meta_q;
  logic             pixel_go;
  logic             weight_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s0_meta_q  <= '0;
    end else if (adv) begin
      s0_valid_q      <= accept;
      s0_meta_q.valid <= pixel_acc && emit;
      s0_meta_q.last  <= last_pos;
      s0_meta_q.orow  <= POS_W'(r_out_q);
      s0_meta_q.ocol  <= POS_W'(c_out_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_item_q <= in_item_i;
      s0_col_q  <= pixel_col_q;
    end
  end

  assign pixel_go  = adv && s0_valid_q && (s0_item_q.command == CMD_PIXEL);
  assign weight_go = adv && s0_valid_q && (s0_item_q.command == CMD_WEIGHT);

  // line store: one entry per column, holding the earlier rows
  logic [LS_W-1:0]               ls_old, ls_new;
  logic signed [SAMPLE_BITS-1:0] ls_old_w [LS_ROWS];
  logic signed [SAMPLE_BITS-1:0] ls_new_w [LS_ROWS];
  logic signed [SAMPLE_BITS-1:0] column   [MAXK];

  s2dcc_line_store #(
    .DEPTH (MAX_IMAGE_SIDE),
    .WIDTH (LS_W)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rd_addr_i (pixel_col_q),
    .wr_en_i   (pixel_go),
    .wr_addr_i (s0_col_q),
    .wr_data_i (ls_new),
    .rd_data_o (ls_old)
  );

  for (genvar r = 0; r < LS_ROWS; r++) begin : g_ls
    assign ls_old_w[r] = ls_old[r*SAMPLE_BITS +: SAMPLE_BITS];
    assign ls_new[r*SAMPLE_BITS +: SAMPLE_BITS] = ls_new_w[r];
    if (r + 1 < LS_ROWS) begin : g_mid
      assign ls_new_w[r] = (r < int'(k_eff) - 2)  ? ls_old_w[r+1] :
                           (r == int'(k_eff) - 2) ? s0_item_q.sample : ls_old_w[r];
    end else begin : g_top
      assign ls_new_w[r] = (r == int'(k_eff) - 2) ? s0_item_q.sample : ls_old_w[r];
    end
  end

  for (genvar r = 0; r < MAXK; r++) begin : g_col
    if (r < MAXK - 1) begin : g_stored
      assign column[r] = (r < int'(k_eff) - 1) ? ls_old_w[r] : s0_item_q.sample;
    end else begin : g_new
      assign column[r] = s0_item_q.sample;
    end
  end

  // kernel weights, flat row-major order
  logic signed [SAMPLE_BITS-1:0] w_q [KSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KSQ; i++) w_q[i] <= '0;
    end else if (weight_go) begin
      for (int i = 0; i < KSQ; i++) begin
        if (int'(s0_item_q.weight_index) == i) w_q[i] <= s0_item_q.sample;
      end
    end
  end

  // window cells
  logic signed [SAMPLE_BITS-1:0] win  [MAXK][MAXK];
  logic signed [PROD_W-1:0]      prod [KSQ];

  for (genvar r = 0; r < MAXK; r++) begin : g_row
    for (genvar c = 0; c < MAXK; c++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] din;
      logic signed [SAMPLE_BITS-1:0] wsel;
      logic signed [SAMPLE_BITS-1:0] cand [1:MAXK];
      logic                          active;

      if (c + 1 < MAXK) begin : g_inner
        assign din = (c + 1 < int'(k_eff)) ? win[r][c+1] : column[r];
      end else begin : g_edge
        assign din = column[r];
      end

      for (genvar kk = 1; kk <= MAXK; kk++) begin : g_cand
        if (r < kk && c < kk) begin : g_in
          assign cand[kk] = w_q[r*kk+c];
        end else begin : g_out
          assign cand[kk] = '0;
        end
      end

      always_comb begin
        wsel = '0;
        for (int kk = 1; kk <= MAXK; kk++) begin
          if (int'(k_eff) == kk) wsel = cand[kk];
        end
      end

      assign active = (r < int'(k_eff)) && (c < int'(k_eff));

      s2dcc_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (pixel_go),
        .adv_i    (adv),
        .active_i (active),
        .din_i    (din),
        .weight_i (wsel),
        .dout_o   (win[r][c]),
        .prod_o   (prod[r*MAXK+c])
      );
    end
  end

  // sum of products
  logic signed [ACC_W-1:0] sum;

  s2dcc_adder_tree #(
    .N_IN (KSQ)
  ) u_tree (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .terms_i (prod),
    .sum_o   (sum)
  );

  // result tags follow the data
  meta_t m_q [MDEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MDEPTH; i++) m_q[i] <= '0;
    end else if (adv) begin
      m_q[0] <= s0_meta_q;
      for (int i = 1; i < MDEPTH; i++) m_q[i] <= m_q[i-1];
    end
  end

  // saturation to the output width
  logic signed [DOT_W-1:0] sat;

  if (ACC_W > DOT_W) begin : g_sat
    always_comb begin
      if (sum[ACC_W-1:DOT_W-1] == '0 || sum[ACC_W-1:DOT_W-1] == '1) begin
        sat = DOT_W'(sum);
      end else if (sum[ACC_W-1]) begin
        sat = {1'b1, {(DOT_W-1){1'b0}}};
      end else begin
        sat = {1'b0, {(DOT_W-1){1'b1}}};
      end
    end
  end else begin : g_ext
    assign sat = DOT_W'(sum);
  end

  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m_q[MDEPTH-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && m_q[MDEPTH-1].valid) begin
      out_q.dot_product <= sat;
      out_q.out_row     <= m_q[MDEPTH-1].orow;
      out_q.out_col     <= m_q[MDEPTH-1].ocol;
      out_q.frame_last  <= m_q[MDEPTH-1].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> verif/tb_strided_2d_cross_correlation_unit.sv
module tb_strided_2d_cross_correlation_unit;
  import s2dcc_pkg::*;

  localparam int IMG_MAX      = 64;
  localparam int KER_MAX      = 5;
  localparam int CELLS        = KER_MAX * KER_MAX;
  localparam int LINE_DEPTH   = (KER_MAX - 1) * IMG_MAX + 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEM_TARGET  = 1950;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_HI = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_LO = {1'b1, {(DOT_W-1){1'b0}}};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;

  strided_2d_cross_correlation_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [SIDE_REG_W-1:0]         side_reg;
  logic [KSIDE_REG_W-1:0]        ksz_reg;
  logic [STRIDE_REG_W-1:0]       step_reg;
  logic signed [SAMPLE_BITS-1:0] weights [CELLS];
  logic signed [SAMPLE_BITS-1:0] lines   [LINE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] window  [CELLS];
  int                            pos_col;
  int                            pos_row;

  in_item_t  stream_q [$];
  out_item_t sums_due [$];
  out_item_t want;

  bit in_fire        = 1'b0;
  bit quiet          = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_budget   = 0;
  int held           = 0;
  int mismatches     = 0;
  int items_sent     = 0;

  function automatic int clamp_side(int v);
    if (v == 0) return 1;
    if (v > IMG_MAX) return IMG_MAX;
    return v;
  endfunction

  function automatic int clamp_k(int v, int n);
    int k;
    k = (v == 0) ? 1 : v;
    if (k > KER_MAX) k = KER_MAX;
    if (k > n) k = n;
    return k;
  endfunction

  function automatic int clamp_step(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void slide_window(in_item_t it);
    int n, k, s, col, row, r0, c0, last, r, c;
    logic signed [SAMPLE_BITS-1:0] column [KER_MAX];
    longint acc;
    out_item_t res;
    n = clamp_side(side_reg);
    k = clamp_k(ksz_reg, n);
    s = clamp_step(step_reg);
    if (it.command == CMD_WEIGHT) begin
      if (it.weight_index < CELLS) weights[it.weight_index] = it.sample;
      return;
    end
    col = (pos_col >= n) ? n - 1 : pos_col;
    row = (pos_row >= n) ? n - 1 : pos_row;
    for (r = 0; r < k - 1; r++) column[r] = lines[r * IMG_MAX + col];
    column[k-1] = it.sample;
    for (r = 0; r < k - 2; r++) lines[r * IMG_MAX + col] = lines[(r + 1) * IMG_MAX + col];
    if (k >= 2) lines[(k - 2) * IMG_MAX + col] = it.sample;
    for (r = 0; r < k; r++) begin
      for (c = 0; c < k - 1; c++) window[r * KER_MAX + c] = window[r * KER_MAX + c + 1];
      window[r * KER_MAX + k - 1] = column[r];
    end
    if (row + 1 >= k && col + 1 >= k) begin
      r0 = row + 1 - k;
      c0 = col + 1 - k;
      if (r0 % s == 0 && c0 % s == 0) begin
        acc = 0;
        for (r = 0; r < k; r++)
          for (c = 0; c < k; c++)
            acc += longint'(window[r * KER_MAX + c]) * longint'(weights[r * k + c]);
        if (acc > longint'(DOT_HI)) acc = longint'(DOT_HI);
        else if (acc < longint'(DOT_LO)) acc = longint'(DOT_LO);
        last = ((n - k) / s) * s;
        res.dot_product = acc[DOT_W-1:0];
        res.out_row     = POS_W'(r0 / s);
        res.out_col     = POS_W'(c0 / s);
        res.frame_last  = (r0 == last && c0 == last);
        sums_due.push_back(res);
      end
    end
    if (col + 1 >= n) begin
      col = 0;
      row = (row + 1 >= n) ? 0 : row + 1;
    end else begin
      col++;
    end
    pos_col = col;
    pos_row = row;
  endfunction

  function automatic void compare_field(string what, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return S_MIN;
        1: return S_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic void queue_weight(int idx, logic signed [SAMPLE_BITS-1:0] v);
    in_item_t it;
    it.command      = CMD_WEIGHT;
    it.weight_index = WIDX_W'(idx);
    it.sample       = v;
    stream_q.push_back(it);
    if (idx < CELLS) items_sent++;
  endfunction

  function automatic void queue_pixel(logic signed [SAMPLE_BITS-1:0] v);
    in_item_t it;
    it.command      = CMD_PIXEL;
    it.weight_index = WIDX_W'($urandom);
    it.sample       = v;
    stream_q.push_back(it);
    items_sent++;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (rst_ni && stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item_i  <= stream_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver; a pending hold-off takes priority over random stalls
  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (held < stall_budget) begin
      out_stall_i <= 1'b1;
      held++;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) slide_window(in_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none, got %p", $time, out_item_o);
      end else begin
        want = sums_due.pop_front();
        compare_field("dot_product", longint'(want.dot_product), longint'(out_item_o.dot_product));
        compare_field("out_row", want.out_row, out_item_o.out_row);
        compare_field("out_col", want.out_col, out_item_o.out_col);
        compare_field("frame_last", want.frame_last, out_item_o.frame_last);
      end
    end
  end

  task automatic wait_empty();
    while (stream_q.size() != 0 || in_valid_i || sums_due.size() != 0) @(posedge clk_i);
  endtask

  // items with no result may still be in the pipe
  task automatic settle();
    wait_empty();
    quiet = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    quiet = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_SIDE:  side_reg = val[SIDE_REG_W-1:0];
      REG_KERNEL_SIDE: ksz_reg  = val[KSIDE_REG_W-1:0];
      REG_STRIDE:      step_reg = val[STRIDE_REG_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      pos_col = 0;
      pos_row = 0;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int side, int ksz, int step, int npix, int mode, bit hold,
                           bit pause_mid);
    int n, k, i;
    logic [CFG_DATA_W-1:0] val;
    settle();
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 84;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 84;
      end
      default: begin
        send_idle_pct  = 16;
        recv_stall_pct = 16;
      end
    endcase
    write_reg(REG_IMAGE_SIDE, CFG_DATA_W'(side));
    // junk above the register width must be dropped
    val      = CFG_DATA_W'($urandom);
    val[2:0] = ksz[2:0];
    write_reg(REG_KERNEL_SIDE, val);
    val      = CFG_DATA_W'($urandom);
    val[2:0] = step[2:0];
    write_reg(REG_STRIDE, val);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    n = clamp_side(side);
    k = clamp_k(ksz, n);
    for (i = 0; i < k * k; i++) queue_weight(i, rand_sample());
    if ($urandom_range(0, 1) == 0) queue_weight($urandom_range(CELLS, 31), rand_sample());
    if (hold) stall_budget += HOLD_CYCLES;
    for (i = 0; i < npix; i++) begin
      if (pause_mid && i == npix / 2) wait_empty();
      if ($urandom_range(0, 39) == 0) queue_weight($urandom_range(0, 31), rand_sample());
      queue_pixel(rand_sample());
    end
  endtask

  initial begin
    int i, side, ksz, step, n, npix, phase;
    side_reg = IMAGE_SIDE_RST;
    ksz_reg  = KERNEL_SIDE_RST;
    step_reg = STRIDE_RST;
    for (i = 0; i < CELLS; i++) begin
      weights[i] = '0;
      window[i]  = '0;
    end
    for (i = 0; i < LINE_DEPTH; i++) lines[i] = '0;
    pos_col = 0;
    pos_row = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full-scale 3x3 window, ignored weight indexes
    write_reg(REG_IMAGE_SIDE, 7'd3);
    write_reg(REG_KERNEL_SIDE, 7'd3);
    write_reg(REG_STRIDE, 7'd1);
    queue_weight(31, S_MAX);
    queue_weight(CELLS, S_MAX);
    for (i = 0; i < 9; i++) queue_weight(i, (i % 2) ? S_MAX : S_MIN);
    for (i = 0; i < 9; i++) queue_pixel((i % 3 == 1) ? S_MAX : S_MIN);
    settle();
    // zero registers act as one
    write_reg(REG_IMAGE_SIDE, '0);
    write_reg(REG_KERNEL_SIDE, '0);
    write_reg(REG_STRIDE, '0);
    queue_weight(0, S_MIN);
    queue_pixel(S_MAX);
    queue_pixel(S_MIN);
    queue_pixel('1);

    run_phase(8, 3, 1, 64, 0, 1'b0, 1'b0);
    run_phase(64, 1, 1, 128, 0, 1'b1, 1'b0);
    run_phase(5, 5, 1, 50, 1, 1'b0, 1'b0);
    run_phase(10, 2, 3, 100, 2, 1'b0, 1'b1);
    run_phase(1, 1, 1, 6, 3, 1'b0, 1'b0);
    run_phase(127, 7, 0, 268, 3, 1'b0, 1'b0);
    run_phase(4, 4, 7, 48, 1, 1'b0, 1'b0);
    run_phase(2, 6, 4, 12, 2, 1'b0, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: side = 0;
        1: side = $urandom_range(13, 127);
        default: side = $urandom_range(1, 12);
      endcase
      ksz  = $urandom_range(0, 7);
      step = $urandom_range(0, 7);
      n    = clamp_side(side);
      npix = n * n * $urandom_range(1, 3);
      if (npix > 300) npix = 300;
      run_phase(side, ksz, step, npix, phase % 4, 1'b0, phase % 7 == 3);
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS strided_2d_cross_correlation_unit");
    end else begin
      $display("FAIL strided_2d_cross_correlation_unit");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL strided_2d_cross_correlation_unit");
    $finish;
  end

endmodule
